// ===== src/fhcs_pkg.sv =====
package fhcs_pkg;

  // Framing and flow parameters
  localparam int CHUNK_BYTES = 512;
  localparam int MAX_LINKS   = 10;
  localparam int ID_BYTES    = 16;
  localparam int HASH_MULT   = 31;
  localparam int WORD_BYTES  = 4;
  localparam int HDR_WORDS   = 3;
  localparam int HDR_BYTES   = ID_BYTES + HDR_WORDS * WORD_BYTES;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int HASH_W = 32;
  localparam int LINK_W = 4;
  localparam int ID_W   = ID_BYTES * BYTE_W;
  localparam int HALF_W = ID_W / 2;
  localparam int WORD_W = WORD_BYTES * BYTE_W;

  // Derived counter widths
  localparam int MAX_LEN    = (2 ** LEN_W) - 1;
  localparam int MAX_CHUNKS = (MAX_LEN + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int OFF_W      = $clog2(CHUNK_BYTES);
  localparam int NUM_W      = LEN_W + 1;
  localparam int HDR_W      = $clog2(HDR_BYTES + 1);
  localparam int IDX_W      = $clog2(ID_BYTES);
  localparam int STEP_W     = $clog2(HASH_W);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input item modes
  localparam logic MODE_DESC = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_HASH,
    FR_MOD,
    FR_PUSH
  } fr_state_e;

  // One queued command: a classified descriptor or a payload byte
  typedef struct packed {
    logic                  is_desc;
    logic [BYTE_W-1:0]     data;
    logic [ID_W-1:0]       id;
    logic [LEN_W-1:0]      len;
    logic [HASH_W-1:0]     hash;
    logic [LINK_W-1:0]     link;
    logic [CNT_W-1:0]      total;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [LINK_W-1:0] link_index;
    logic [HASH_W-1:0] pkt_hash;
    logic              chunk_last;
    logic              packet_last;
    logic              run_last;
  } res_t;

endpackage

// ===== src/fhcs_fifo.sv =====
module fhcs_fifo import fhcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== src/fhcs_front.sv =====
module fhcs_front import fhcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                mode_i,
  input  logic [HALF_W-1:0]   uuid_high_i,
  input  logic [HALF_W-1:0]   uuid_low_i,
  input  logic [LEN_W-1:0]    payload_length_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [LINK_W-1:0]   link_count_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cmd_t                q_cmd_o
);

  fr_state_e state_q, state_d;

  logic [STEP_W-1:0]                 step_q, step_d;
  logic [ID_BYTES-1:0][BYTE_W-1:0]   id_q, id_d;
  logic [LEN_W-1:0]                  len_q, len_d;
  logic [LINK_W-1:0]                 lc_q, lc_d;
  logic [HASH_W-1:0]                 hash_q, hash_d;
  logic [LINK_W-1:0]                 lrem_q, lrem_d;
  logic [CNT_W-1:0]                  tot_q, tot_d;

  logic                              acc;
  logic [LINK_W-1:0]                 lc_clamp;
  logic [BYTE_W-1:0]                 id_byte;
  logic [HASH_W-1:0]                 hash_next;
  logic [LINK_W:0]                   lr2;
  logic [NUM_W-1:0]                  len_round;
  cmd_t                              data_cmd, desc_cmd;

  assign full = (state_q != FR_IDLE) || q_full_i;
  assign acc  = push && !full;

  // Link count as used: zero reads as one, too large reads as the maximum
  always_comb begin
    if (link_count_i == '0) begin
      lc_clamp = LINK_W'(1);
    end else if (link_count_i > LINK_W'(MAX_LINKS)) begin
      lc_clamp = LINK_W'(MAX_LINKS);
    end else begin
      lc_clamp = link_count_i;
    end
  end

  // One identifier byte per cycle into the hash, most significant first
  assign id_byte   = id_q[IDX_W'(ID_BYTES-1) - step_q[IDX_W-1:0]];
  assign hash_next = hash_q * HASH_W'(HASH_MULT) + HASH_W'(id_byte);

  // Bit-serial remainder step: hash by link count
  assign lr2 = {lrem_q, hash_q[STEP_W'(HASH_W-1) - step_q]};

  // Chunk total = ceil(len / CHUNK_BYTES); chunk size is a power of two
  assign len_round = NUM_W'(payload_length_i) + NUM_W'(CHUNK_BYTES - 1);

  // Commands toward the back
  always_comb begin
    data_cmd         = '0;
    data_cmd.is_desc = 1'b0;
    data_cmd.data    = data_byte_i;

    desc_cmd         = '0;
    desc_cmd.is_desc = 1'b1;
    desc_cmd.id      = id_q;
    desc_cmd.len     = len_q;
    desc_cmd.hash    = hash_q;
    desc_cmd.link    = lrem_q;
    desc_cmd.total   = tot_q;
  end

  // Next state and datapath
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    id_d     = id_q;
    len_d    = len_q;
    lc_d     = lc_q;
    hash_d   = hash_q;
    lrem_d   = lrem_q;
    tot_d    = tot_q;
    q_push_o = 1'b0;
    q_cmd_o  = data_cmd;

    unique case (state_q)
      FR_IDLE: begin
        if (acc) begin
          if (mode_i == MODE_DESC) begin
            id_d    = {uuid_high_i, uuid_low_i};
            len_d   = payload_length_i;
            lc_d    = lc_clamp;
            hash_d  = '0;
            lrem_d  = '0;
            tot_d   = CNT_W'(len_round >> OFF_W);
            step_d  = '0;
            state_d = FR_HASH;
          end else begin
            q_push_o = 1'b1;
          end
        end
      end
      FR_HASH: begin
        hash_d = hash_next;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(ID_BYTES-1)) begin
          step_d  = '0;
          state_d = FR_MOD;
        end
      end
      FR_MOD: begin
        if (lr2 >= {1'b0, lc_q}) begin
          lrem_d = LINK_W'(lr2 - {1'b0, lc_q});
        end else begin
          lrem_d = LINK_W'(lr2);
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(HASH_W-1)) begin
          step_d  = '0;
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        q_cmd_o = desc_cmd;
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = FR_IDLE;
        end
      end
      default: begin
        state_d = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    len_q  <= len_d;
    lc_q   <= lc_d;
    hash_q <= hash_d;
    lrem_q <= lrem_d;
    tot_q  <= tot_d;
  end

endmodule

// ===== src/fhcs_back.sv =====
module fhcs_back import fhcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t q_cmd_i,
  input  logic q_empty_i,
  output logic q_pop_o,
  input  logic pop_i,
  output logic out_valid_o,
  output res_t res_o
);

  logic [ID_BYTES-1:0][BYTE_W-1:0]   id_q, id_d;
  logic [LEN_W-1:0]                  left_q, left_d;
  logic [OFF_W-1:0]                  off_q, off_d;
  logic [CNT_W-1:0]                  num_q, num_d;
  logic [CNT_W-1:0]                  total_q, total_d;
  logic [LINK_W-1:0]                 link_q, link_d;
  logic [HASH_W-1:0]                 hash_q, hash_d;
  logic [HDR_W-1:0]                  hdr_q, hdr_d;
  logic                              out_valid_q, out_valid_d;
  res_t                              res_q, res_d;

  logic                              adv;
  logic                              emit;
  logic [LEN_W-1:0]                  clen;
  logic [HDR_BYTES-1:0][BYTE_W-1:0]  hdr_v;
  logic [BYTE_W-1:0]                 hdr_byte;
  logic [OFF_W:0]                    off_n;
  logic                              plast, clast;

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Output slot frees when empty or taken this cycle
  assign adv = !out_valid_q || pop_i;

  // Header fields of the chunk about to start
  assign clen  = (left_q > LEN_W'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES) : left_q;
  assign hdr_v = {id_q, WORD_W'(num_q), WORD_W'(total_q), WORD_W'(clen)};
  assign hdr_byte = hdr_v[HDR_W'(HDR_BYTES-1) - hdr_q];

  // End-of-chunk and end-of-packet flags for the data byte
  assign off_n = {1'b0, off_q} + 1'b1;
  assign plast = (left_q == LEN_W'(1));
  assign clast = plast || (off_n >= (OFF_W+1)'(CHUNK_BYTES));

  always_comb begin
    id_d     = id_q;
    left_d   = left_q;
    off_d    = off_q;
    num_d    = num_q;
    total_d  = total_q;
    link_d   = link_q;
    hash_d   = hash_q;
    hdr_d    = hdr_q;
    res_d    = res_q;
    q_pop_o  = 1'b0;
    emit     = 1'b0;

    if (adv && !q_empty_i) begin
      if (q_cmd_i.is_desc) begin
        // new packet, drops whatever was unfinished
        id_d    = q_cmd_i.id;
        left_d  = q_cmd_i.len;
        off_d   = '0;
        num_d   = '0;
        total_d = q_cmd_i.total;
        link_d  = q_cmd_i.link;
        hash_d  = q_cmd_i.hash;
        hdr_d   = '0;
        q_pop_o = 1'b1;
      end else if (left_q == '0) begin
        // byte past the declared length
        q_pop_o = 1'b1;
      end else if ((off_q == '0) && (hdr_q != HDR_W'(HDR_BYTES))) begin
        // header byte ahead of the first byte of a chunk
        emit              = 1'b1;
        res_d.out_byte    = hdr_byte;
        res_d.link_index  = link_q;
        res_d.pkt_hash    = hash_q;
        res_d.chunk_last  = 1'b0;
        res_d.packet_last = 1'b0;
        res_d.run_last    = 1'b0;
        hdr_d             = hdr_q + 1'b1;
      end else begin
        // payload byte, closes the run of this transaction
        emit              = 1'b1;
        res_d.out_byte    = q_cmd_i.data;
        res_d.link_index  = link_q;
        res_d.pkt_hash    = hash_q;
        res_d.chunk_last  = clast;
        res_d.packet_last = plast;
        res_d.run_last    = 1'b1;
        q_pop_o           = 1'b1;
        hdr_d             = '0;
        left_d            = left_q - 1'b1;
        if (clast) begin
          off_d = '0;
          num_d = num_q + 1'b1;
        end else begin
          off_d = OFF_W'(off_n);
        end
      end
    end

    out_valid_d = adv ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q        <= '0;
      left_q      <= '0;
      off_q       <= '0;
      num_q       <= '0;
      total_q     <= '0;
      link_q      <= '0;
      hash_q      <= '0;
      hdr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      id_q        <= id_d;
      left_q      <= left_d;
      off_q       <= off_d;
      num_q       <= num_d;
      total_q     <= total_d;
      link_q      <= link_d;
      hash_q      <= hash_d;
      hdr_q       <= hdr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== src/flow_hash_chunk_segmenter.sv =====
// Descriptor: full stays high (longer while the queue is full) through 16 hash
//   steps and 32 link remainder steps, one per cycle, and then while it is queued.
// Payload bytes enter at one per cycle while full is low, via a 4-entry command queue;
//   the back emits one result per cycle while results are popped, a chunk's first
//   byte after its 28 header bytes; each byte passes the queue and result register.
// Reset is asynchronous, active low; no clearing pass, link count resets to 1.
module flow_hash_chunk_segmenter import fhcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              mode_i,
  input  logic [HALF_W-1:0] uuid_high_i,
  input  logic [HALF_W-1:0] uuid_low_i,
  input  logic [LEN_W-1:0]  payload_length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [LINK_W-1:0] link_index_o,
  output logic [HASH_W-1:0] pkt_hash_o,
  output logic              chunk_last_o,
  output logic              packet_last_o,
  output logic              run_last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LINK_W-1:0] cfg_data_i
);

  logic [LINK_W-1:0] link_count_q;
  logic              q_push, q_full, q_pop, q_empty;
  cmd_t              q_wr_cmd, q_rd_cmd;
  logic              out_valid;
  res_t              res;

  // Link count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_count_q <= LINK_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      link_count_q <= cfg_data_i;
    end
  end

  fhcs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .uuid_high_i      (uuid_high_i),
    .uuid_low_i       (uuid_low_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .link_count_i     (link_count_q),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (q_wr_cmd)
  );

  fhcs_fifo u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_push),
    .wr_data_i (q_wr_cmd),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_rd_cmd),
    .empty_o   (q_empty)
  );

  fhcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_cmd_i     (q_rd_cmd),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  // Result ports
  assign empty         = !out_valid;
  assign out_byte_o    = res.out_byte;
  assign link_index_o  = res.link_index;
  assign pkt_hash_o    = res.pkt_hash;
  assign chunk_last_o  = res.chunk_last;
  assign packet_last_o = res.packet_last;
  assign run_last_o    = res.run_last;

  // A full command queue must hold off the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> full)
    else $error("input accepted while command queue full");

  // Only the payload byte closes a chunk, and it always ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chunk_last_o) |-> run_last_o)
    else $error("chunk end on a header byte");

  // Packet end is always a chunk end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && packet_last_o) |-> chunk_last_o)
    else $error("packet end without chunk end");

  // Selected link stays within the link range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (link_index_o < LINK_W'(MAX_LINKS)))
    else $error("link index out of range");

endmodule

// ===== verif/flow_hash_chunk_segmenter_tb.sv =====
`timescale 1ns / 1ps

module flow_hash_chunk_segmenter_tb;
  import fhcs_pkg::*;

  // Descriptor hashing holds the front busy; the settle time allows a margin
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTED    = 40;
  localparam int STREAM_BYTES   = 40;
  localparam int PHASE_ITEMS    = 22;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic              mode_i;
  logic [HALF_W-1:0] uuid_high_i;
  logic [HALF_W-1:0] uuid_low_i;
  logic [LEN_W-1:0]  payload_length_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              empty;
  logic              pop;
  logic [BYTE_W-1:0] out_byte_o;
  logic [LINK_W-1:0] link_index_o;
  logic [HASH_W-1:0] pkt_hash_o;
  logic              chunk_last_o;
  logic              packet_last_o;
  logic              run_last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [LINK_W-1:0] cfg_data_i;

  flow_hash_chunk_segmenter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .uuid_high_i      (uuid_high_i),
    .uuid_low_i       (uuid_low_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .link_index_o     (link_index_o),
    .pkt_hash_o       (pkt_hash_o),
    .chunk_last_o     (chunk_last_o),
    .packet_last_o    (packet_last_o),
    .run_last_o       (run_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // Clock: 2 ns period
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Segmenter state mirror
  logic [ID_W-1:0]   seg_id;
  logic [LEN_W-1:0]  seg_left;
  int unsigned       seg_offset;
  int unsigned       seg_chunk_idx;
  int unsigned       seg_chunk_cnt;
  logic [LINK_W-1:0] seg_link;
  logic [HASH_W-1:0] seg_hash;
  logic [LINK_W-1:0] seg_link_count;

  // Frame bytes still owed by the DUT, oldest first
  res_t frame_q[$];

  bit          gaps_on;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned items_used;
  int unsigned items_dropped;
  int unsigned bytes_checked;
  int unsigned chunks_seen;
  int unsigned cfg_writes;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void queue_frame_byte(input logic [BYTE_W-1:0] b, input logic cl,
                                           input logic pl, input logic rl);
    res_t r;
    r.out_byte    = b;
    r.link_index  = seg_link;
    r.pkt_hash    = seg_hash;
    r.chunk_last  = cl;
    r.packet_last = pl;
    r.run_last    = rl;
    frame_q.push_back(r);
  endfunction

  // Predict the frame bytes that one accepted item produces
  function automatic void segment_item(input logic m, input logic [HALF_W-1:0] hi,
                                       input logic [HALF_W-1:0] lo,
                                       input logic [LEN_W-1:0] len,
                                       input logic [BYTE_W-1:0] data);
    logic [LINK_W-1:0] lc;
    logic [WORD_W-1:0] words [HDR_WORDS];
    int unsigned       clen;
    logic              clast;
    logic              plast;
    if (m == MODE_DESC) begin
      // New descriptor: latch, hash, pick link; drops any open packet
      seg_id        = {hi, lo};
      seg_left      = len;
      seg_offset    = 0;
      seg_chunk_idx = 0;
      seg_chunk_cnt = (int'(len) + CHUNK_BYTES - 1) / CHUNK_BYTES;
      seg_hash      = '0;
      for (int k = 0; k < ID_BYTES; k++)
        seg_hash = seg_hash * HASH_MULT + seg_id[(ID_BYTES - 1 - k) * BYTE_W +: BYTE_W];
      lc = seg_link_count;
      if (lc == 0) lc = LINK_W'(1);
      if (lc > MAX_LINKS) lc = LINK_W'(MAX_LINKS);
      seg_link = LINK_W'(seg_hash % lc);
      items_used++;
      return;
    end
    // Payload byte past the declared length, or with no packet open
    if (seg_left == 0) begin
      items_dropped++;
      return;
    end
    items_used++;
    clen = int'(seg_left) + seg_offset;
    if (clen > CHUNK_BYTES) clen = CHUNK_BYTES;
    // Chunk header goes out ahead of the first byte of each chunk
    if (seg_offset == 0) begin
      words[0] = seg_chunk_idx;
      words[1] = seg_chunk_cnt;
      words[2] = clen;
      for (int k = 0; k < ID_BYTES; k++)
        queue_frame_byte(seg_id[(ID_BYTES - 1 - k) * BYTE_W +: BYTE_W], 1'b0, 1'b0, 1'b0);
      for (int k = 0; k < HDR_WORDS * WORD_BYTES; k++)
        queue_frame_byte(words[k / WORD_BYTES][(WORD_BYTES - 1 - k % WORD_BYTES) * BYTE_W
                         +: BYTE_W], 1'b0, 1'b0, 1'b0);
    end
    seg_offset++;
    seg_left--;
    plast = (seg_left == 0);
    clast = plast || (seg_offset >= CHUNK_BYTES);
    queue_frame_byte(data, clast, plast, 1'b1);
    if (clast) begin
      seg_offset = 0;
      seg_chunk_idx++;
      chunks_seen++;
    end
  endfunction

  function automatic logic [HALF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Push one item; fields change at the falling edge, acceptance seen at the rising edge
  task automatic send_item(input logic m, input logic [HALF_W-1:0] hi,
                           input logic [HALF_W-1:0] lo, input logic [LEN_W-1:0] len,
                           input logic [BYTE_W-1:0] data);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(99) < 30) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push             <= 1'b1;
    mode_i           <= m;
    uuid_high_i      <= hi;
    uuid_low_i       <= lo;
    payload_length_i <= len;
    data_byte_i      <= data;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    segment_item(m, hi, lo, len, data);
    @(negedge clk_i);
  endtask

  task automatic send_desc(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                           input logic [LEN_W-1:0] len);
    send_item(MODE_DESC, hi, lo, len, BYTE_W'($urandom));
  endtask

  task automatic send_data(input logic [BYTE_W-1:0] data);
    send_item(MODE_DATA, rand64(), rand64(), LEN_W'($urandom), data);
  endtask

  // Hold the sender until every frame byte is out and the front has settled
  task automatic wait_idle();
    push <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_link_count(input logic [LINK_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    seg_link_count = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stray byte before any descriptor, then an all-zero identifier under the reset link count
  task automatic test_reset_defaults();
    send_data(8'h5a);
    send_desc('0, '0, 16'd1);
    send_data(8'h00);
  endtask

  // All-ones identifier and byte extremes, plus one excess byte
  task automatic test_field_extremes();
    send_desc('1, '1, 16'd3);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'ha5);
    send_data(8'h3c);
  endtask

  task automatic test_zero_length();
    send_desc(rand64(), rand64(), 16'd0);
    send_data(8'h11);
    send_data(8'hee);
  endtask

  // Longest declared packet cut short by a fresh descriptor
  task automatic test_abandon();
    send_desc(rand64(), rand64(), 16'hffff);
    send_data(8'h01);
    send_data(8'h02);
    send_desc(rand64(), rand64(), 16'd2);
    send_data(8'h80);
    send_data(8'h7f);
  endtask

  // Zero, largest legal and oversized link counts; link fixed at descriptor time
  task automatic test_link_counts();
    write_link_count(4'd0);
    send_desc(rand64(), rand64(), 16'd1);
    send_data(BYTE_W'($urandom));
    write_link_count(LINK_W'(MAX_LINKS));
    send_desc(rand64(), rand64(), 16'd1);
    send_data(BYTE_W'($urandom));
    write_link_count(4'd15);
    send_desc(rand64(), rand64(), 16'd1);
    write_link_count(4'd3);
    send_data(BYTE_W'($urandom));
  endtask

  // One packet streamed with no idling on either side
  task automatic test_no_idle_stream();
    gaps_on = 1'b0;
    write_link_count(4'd7);
    send_desc(rand64(), rand64(), LEN_W'(STREAM_BYTES));
    repeat (STREAM_BYTES) send_data(BYTE_W'($urandom));
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic send_random_packet();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // Well-formed packet, sometimes with trailing excess bytes
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 24);
      send_desc(rand64(), rand64(), LEN_W'(len));
      repeat (len) send_data(BYTE_W'($urandom));
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) send_data(BYTE_W'($urandom));
    end else if (pick < 85) begin
      // Any length, left unfinished
      send_desc(rand64(), rand64(), LEN_W'($urandom));
      repeat ($urandom_range(0, 5)) send_data(BYTE_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) send_data(BYTE_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    for (int ph = 0; ph < 4; ph++) begin
      write_link_count(LINK_W'($urandom_range(0, 15)));
      goal = items_used + PHASE_ITEMS;
      while (items_used < goal) send_random_packet();
    end
  endtask

  // Receiver: pop at random, or always while idling is off
  always @(negedge clk_i) begin
    if (rst_ni) pop <= !gaps_on || ($urandom_range(99) >= 30);
  end

  // Compare each popped transaction with the oldest expected frame byte
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (frame_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", out_byte_o));
      end else begin
        want = frame_q.pop_front();
        bytes_checked++;
        if (out_byte_o !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.out_byte));
        if (link_index_o !== want.link_index)
          report_mismatch($sformatf("link_index %0d, want %0d", link_index_o,
                                    want.link_index));
        if (pkt_hash_o !== want.pkt_hash)
          report_mismatch($sformatf("pkt_hash %08h, want %08h", pkt_hash_o, want.pkt_hash));
        if (chunk_last_o !== want.chunk_last)
          report_mismatch($sformatf("chunk_last %b, want %b", chunk_last_o, want.chunk_last));
        if (packet_last_o !== want.packet_last)
          report_mismatch($sformatf("packet_last %b, want %b", packet_last_o,
                                    want.packet_last));
        if (run_last_o !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b", run_last_o, want.run_last));
      end
    end
  end

  // Watchdog on cycles with no transaction on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    mode_i           = MODE_DESC;
    uuid_high_i      = '0;
    uuid_low_i       = '0;
    payload_length_i = '0;
    data_byte_i      = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    gaps_on          = 1'b1;
    errors           = 0;
    idle_cycles      = 0;
    items_used       = 0;
    items_dropped    = 0;
    bytes_checked    = 0;
    chunks_seen      = 0;
    cfg_writes       = 0;
    seg_id           = '0;
    seg_left         = '0;
    seg_offset       = 0;
    seg_chunk_idx    = 0;
    seg_chunk_cnt    = 0;
    seg_link         = '0;
    seg_hash         = '0;
    seg_link_count   = 4'd1;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_zero_length();
    test_abandon();
    test_link_counts();
    test_no_idle_stream();
    test_random_traffic();

    wait_idle();
    if (frame_q.size() != 0)
      report_mismatch($sformatf("%0d frame bytes never arrived", frame_q.size()));

    $display("Run: %0d items used, %0d dropped, %0d link count writes incl. 0 and 15",
             items_used, items_dropped, cfg_writes);
    $display("Run: %0d frame bytes checked over %0d completed chunks, %0d mismatches",
             bytes_checked, chunks_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
